// ===== rtl/sbc_pkg.sv =====
// Package: types, constants and codes for the size-budget cache.
package sbc_pkg;
  localparam int unsigned EntriesDefault = 32;
  localparam int unsigned SizeBits       = 24;
  localparam int unsigned KeyBits        = 32;
  localparam logic [23:0] BudgetReset    = 24'd65536;

  typedef enum logic [1:0] {
    KindStore = 2'd0,
    KindFetch = 2'd1,
    KindFree  = 2'd2,
    KindReset = 2'd3
  } kind_e;

  typedef enum logic [3:0] {
    StStored  = 4'd0,
    StHit     = 4'd1,
    StMiss    = 4'd2,
    StTooBig  = 4'd3,
    StNoRoom  = 4'd4,
    StFreed   = 4'd5,
    StNotFnd  = 4'd6,
    StEvicted = 4'd7,
    StResetN  = 4'd8
  } status_e;

  typedef enum logic {
    SIdle,
    SScan
  } state_e;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] entry_id;
    logic [31:0] data_handle;
    logic [23:0] entry_size;
    logic        touch;
    logic        notify;
  } req_t;

  typedef struct packed {
    logic [3:0]  status;
    logic [31:0] entry_id_res;
    logic [31:0] data_handle_res;
    logic [23:0] used_size;
    logic [5:0]  entry_count;
    logic        last;
  } res_t;
endpackage

// ===== rtl/sbc_if.sv =====
// Valid/ready channel interface carrying one payload.
interface sbc_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/sbc_mem.sv =====
// Slot memory: one write port, one registered read port.
module sbc_mem #(
  parameter int unsigned Entries = 32,
  parameter int unsigned Width   = 8
) (
  input  logic                       clk_i,
  input  logic                       we_i,
  input  logic [$clog2(Entries)-1:0] waddr_i,
  input  logic [Width-1:0]           wdata_i,
  input  logic [$clog2(Entries)-1:0] raddr_i,
  output logic [Width-1:0]           rdata_o
);
  logic [Width-1:0] mem [Entries];

  always_ff @(posedge clk_i) begin
    if (we_i) mem[waddr_i] <= wdata_i;
    rdata_o <= mem[raddr_i];
  end
endmodule

// ===== rtl/size_budget_oldest_evict_cache.sv =====
// Top level: size-budget cache with oldest-stamp eviction.
//  channel | dir | handshake     | payload
//  req     | in  | valid/ready   | kind, entry_id, data_handle, entry_size, touch, notify
//  res     | out | valid/ready   | status, entry_id_res, data_handle_res, used_size,
//          |     |               | entry_count, last
//  cfg     | in  | cfg_we_i      | max_total_size
// One transaction at a time, taken only when idle with the result register empty.
// A pass reads the slot memory one slot per cycle, issuing the reads, taking each row
// from the registered read port, then deciding. A store does one pass per eviction
// plus one, other kinds one pass. The scan holds while a result waits untaken in the
// output register. After reset all slots are empty; valid bits are flops.
module size_budget_oldest_evict_cache
  import sbc_pkg::*;
#(
  parameter int unsigned ENTRIES = EntriesDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [23:0] cfg_wdata_i,
  sbc_if.sink         req,
  sbc_if.source       res
);
  localparam int unsigned IW = $clog2(ENTRIES);
  localparam int unsigned CW = $clog2(ENTRIES + 1);
  localparam int unsigned MW = KeyBits + 32 + SizeBits + 32 + 32;

  state_e               state_q, state_d;
  req_t                 rq_q, rq_d;
  logic [23:0]          budget_q, budget_d;
  logic [ENTRIES-1:0]   valid_q, valid_d;
  logic [31:0]          acc_q, acc_d;
  logic [SizeBits-1:0]  used_q, used_d;
  logic [IW:0]          rptr_q, rptr_d;   // next slot to read
  logic [IW-1:0]        cptr_q, cptr_d;   // slot whose row arrives this cycle
  logic                 cval_q, cval_d;
  logic                 best_v_q, best_v_d;
  logic [IW-1:0]        best_q, best_d;
  logic [31:0]          best_stamp_q, best_stamp_d;
  logic [KeyBits-1:0]   best_key_q, best_key_d;
  logic [31:0]          best_data_q, best_data_d;
  logic [SizeBits-1:0]  best_size_q, best_size_d;
  logic                 found_q, found_d;
  logic                 hold_v_q, hold_v_d;  // notice held until the next one shows up or the pass ends
  res_t                 hold_q, hold_d;
  logic                 out_v_q, out_v_d;
  res_t                 out_q, out_d;

  // memory fields
  logic                 we;
  logic [IW-1:0]        waddr, raddr;
  logic [MW-1:0]        wdata, rdata;
  logic [KeyBits-1:0]   m_key;
  logic [31:0]          m_data, m_age, m_ord;
  logic [SizeBits-1:0]  m_size;
  assign {m_key, m_data, m_size, m_age, m_ord} = rdata;

  sbc_mem #(.Entries(ENTRIES), .Width(MW)) u_mem (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(wdata),
    .raddr_i(raddr), .rdata_o(rdata));

  // request fields narrowed
  logic [KeyBits-1:0]  key;
  logic [SizeBits-1:0] sz;
  assign key = rq_q.entry_id[KeyBits-1:0];
  assign sz  = rq_q.entry_size[SizeBits-1:0];

  logic [CW-1:0] cnt;
  always_comb begin
    cnt = '0;
    for (int i = 0; i < ENTRIES; i++) cnt = cnt + CW'(valid_q[i]);
  end

  logic [SizeBits:0] need;
  logic        fits, too_big, out_free, issue_done, scan_done, cur_match, adv, evict_now;
  logic [IW-1:0] free_slot;
  logic        has_free;
  assign need       = {1'b0, used_q} + {1'b0, sz};
  assign fits       = need <= (SizeBits + 1)'(budget_q);
  assign too_big    = sz > SizeBits'(budget_q);
  assign out_free   = !out_v_q || res.ready;
  assign issue_done = (rptr_q == (IW + 1)'(ENTRIES));
  assign scan_done  = issue_done && !cval_q;
  assign cur_match  = cval_q && valid_q[cptr_q] && (m_key == key);
  assign adv        = (state_q == SScan) && out_free;
  assign evict_now  = (rq_q.kind == KindStore) && !too_big && !fits && best_v_q;
  always_comb begin
    has_free = 1'b0;
    free_slot = '0;
    for (int i = ENTRIES - 1; i >= 0; i--)
      if (!valid_q[i]) begin has_free = 1'b1; free_slot = IW'(i); end
  end

  function automatic logic [SizeBits-1:0] drop(logic [SizeBits-1:0] u,
                                                logic [SizeBits-1:0] s);
    drop = (s > u) ? '0 : u - s;
  endfunction

  assign req.ready = (state_q == SIdle) && !out_v_q;
  assign res.valid = out_v_q;
  assign res.data  = out_q;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      SIdle: if (req.valid && req.ready) state_d = SScan;
      SScan: if (scan_done && out_free && !evict_now) state_d = SIdle;
      default: state_d = SIdle;
    endcase
  end

  // datapath; the scan holds while a result waits, re-reading the current slot
  always_comb begin
    rq_d = rq_q; budget_d = budget_q; valid_d = valid_q; acc_d = acc_q; used_d = used_q;
    rptr_d = rptr_q; cptr_d = cptr_q; cval_d = cval_q;
    best_v_d = best_v_q; best_d = best_q; best_stamp_d = best_stamp_q;
    best_key_d = best_key_q; best_data_d = best_data_q; best_size_d = best_size_q;
    found_d = found_q; hold_v_d = hold_v_q; hold_d = hold_q;
    out_v_d = out_v_q && !res.ready; out_d = out_q;
    we = 1'b0; waddr = free_slot;
    wdata = {key, rq_q.data_handle, sz, acc_q, acc_q};
    raddr = adv ? rptr_q[IW-1:0] : cptr_q;

    if (cfg_we_i) budget_d = cfg_wdata_i;

    // take a new transaction
    if (state_q == SIdle && req.valid && req.ready) begin
      rq_d = req.data; rptr_d = '0; cval_d = 1'b0;
      best_v_d = 1'b0; found_d = 1'b0; hold_v_d = 1'b0;
    end

    if (adv) begin
      // issue the next read
      if (!issue_done) begin
        cptr_d = rptr_q[IW-1:0];
        rptr_d = rptr_q + (IW + 1)'(1);
        cval_d = 1'b1;
      end else cval_d = 1'b0;

      // look at the row that arrived
      if (cval_q) begin
        unique case (kind_e'(rq_q.kind))
          KindStore: if (valid_q[cptr_q] && (!best_v_q || m_age < best_stamp_q)) begin
            best_v_d = 1'b1; best_d = cptr_q; best_stamp_d = m_age;
            best_key_d = m_key; best_data_d = m_data; best_size_d = m_size;
          end
          KindFetch: if (cur_match && (!best_v_q || m_ord > best_stamp_q)) begin
            best_v_d = 1'b1; best_d = cptr_q; best_stamp_d = m_ord;
            best_key_d = m_key; best_data_d = m_data; best_size_d = m_size;
          end
          KindFree: if (cur_match) begin
            found_d = 1'b1;
            valid_d[cptr_q] = 1'b0;
            used_d = drop(used_q, m_size);
            if (rq_q.notify) begin
              if (hold_v_q) begin out_v_d = 1'b1; out_d = hold_q; end
              hold_v_d = 1'b1;
              hold_d = '{StFreed, 32'(key), m_data, 24'(drop(used_q, m_size)),
                         6'(cnt - CW'(1)), 1'b0};
            end
          end
          default: if (valid_q[cptr_q]) begin
            valid_d[cptr_q] = 1'b0;
            used_d = drop(used_q, m_size);
            if (hold_v_q) begin out_v_d = 1'b1; out_d = hold_q; end
            hold_v_d = 1'b1;
            hold_d = '{StResetN, 32'(m_key), m_data, 24'(drop(used_q, m_size)),
                       6'(cnt - CW'(1)), 1'b0};
          end
        endcase
      end

      // end of pass: decide
      if (scan_done) begin
        unique case (kind_e'(rq_q.kind))
          KindStore: if (too_big) begin
            out_v_d = 1'b1;
            out_d = '{StTooBig, 32'(key), 32'd0, 24'(used_q), 6'(cnt), 1'b1};
          end else if (evict_now) begin
            // evict oldest, report, then rescan
            valid_d[best_q] = 1'b0;
            used_d = drop(used_q, best_size_q);
            out_v_d = 1'b1;
            out_d = '{StEvicted, 32'(best_key_q), best_data_q,
                      24'(drop(used_q, best_size_q)), 6'(cnt - CW'(1)), 1'b0};
            rptr_d = '0; cval_d = 1'b0; best_v_d = 1'b0;
          end else if (has_free) begin
            we = 1'b1;
            valid_d[free_slot] = 1'b1;
            acc_d = acc_q + 32'd1;
            used_d = need[SizeBits-1:0];
            out_v_d = 1'b1;
            out_d = '{StStored, 32'(key), 32'd0, 24'(need[SizeBits-1:0]),
                      6'(cnt + CW'(1)), 1'b1};
          end else begin
            out_v_d = 1'b1;
            out_d = '{StNoRoom, 32'(key), 32'd0, 24'(used_q), 6'(cnt), 1'b1};
          end
          KindFetch: begin
            out_v_d = 1'b1;
            if (!best_v_q) begin
              out_d = '{StMiss, 32'(key), 32'd0, 24'(used_q), 6'(cnt), 1'b1};
            end else begin
              out_d = '{StHit, 32'(key), best_data_q, 24'(used_q), 6'(cnt), 1'b1};
              if (rq_q.touch) begin
                we = 1'b1; waddr = best_q;
                wdata = {best_key_q, best_data_q, best_size_q, acc_q, best_stamp_q};
                acc_d = acc_q + 32'd1;
              end
            end
          end
          KindFree: begin
            if (!found_q) begin
              out_v_d = 1'b1;
              out_d = '{StNotFnd, 32'(key), 32'd0, 24'(used_q), 6'(cnt), 1'b1};
            end else if (hold_v_q) begin
              out_v_d = 1'b1; out_d = hold_q; out_d.last = 1'b1; hold_v_d = 1'b0;
            end
          end
          default: begin
            used_d = '0;
            if (hold_v_q) begin
              out_v_d = 1'b1; out_d = hold_q; out_d.last = 1'b1; hold_v_d = 1'b0;
            end
          end
        endcase
      end
    end
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle; rq_q <= '0; budget_q <= BudgetReset; valid_q <= '0;
      acc_q <= '0; used_q <= '0; rptr_q <= '0; cptr_q <= '0; cval_q <= 1'b0;
      best_v_q <= 1'b0; best_q <= '0; best_stamp_q <= '0;
      best_key_q <= '0; best_data_q <= '0; best_size_q <= '0;
      found_q <= 1'b0; hold_v_q <= 1'b0; hold_q <= '0;
      out_v_q <= 1'b0; out_q <= '0;
    end else begin
      state_q <= state_d; rq_q <= rq_d; budget_q <= budget_d; valid_q <= valid_d;
      acc_q <= acc_d; used_q <= used_d; rptr_q <= rptr_d; cptr_q <= cptr_d;
      cval_q <= cval_d;
      best_v_q <= best_v_d; best_q <= best_d; best_stamp_q <= best_stamp_d;
      best_key_q <= best_key_d; best_data_q <= best_data_d; best_size_q <= best_size_d;
      found_q <= found_d; hold_v_q <= hold_v_d; hold_q <= hold_d;
      out_v_q <= out_v_d; out_q <= out_d;
    end
  end
endmodule

// ===== rtl/sbc_checker.sv =====
// Port-level checker for the cache, bound to the top level.
module sbc_checker
  import sbc_pkg::*;
(
  input logic clk_i,
  input logic rst_ni,
  input logic req_valid, req_ready,
  input logic res_valid, res_ready,
  input res_t res_data
);
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid && !res_ready |=> res_valid && $stable(res_data)) else $error("res hold");
  a_stat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid |-> res_data.status <= 4'd8) else $error("bad status");
  a_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid |-> res_data.entry_count <= 6'd32) else $error("count");
  a_rdy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid && req_ready |-> !res_valid) else $error("accept with result pending");
endmodule

bind size_budget_oldest_evict_cache sbc_checker u_chk (
  .clk_i, .rst_ni, .req_valid(req.valid), .req_ready(req.ready),
  .res_valid(res.valid), .res_ready(res.ready), .res_data(res.data));

// ===== dv/sbc_tb_if.sv =====
// Testbench package: directed stimulus row type.
`timescale 1ns / 1ps
package sbc_tb_pkg;
  import sbc_pkg::*;
  // Directed stimulus row; chk_first set when the first result is typed in.
  typedef struct {
    req_t    req;
    logic    chk_first;
    status_e st_first;
  } dir_row_t;
endpackage

// ===== dv/testbench.sv =====
// Testbench for the size-budget cache: directed table plus random traffic.
`timescale 1ns / 1ps
module testbench;
  import sbc_pkg::*;
  import sbc_tb_pkg::*;

  localparam int Slots = 32;
  localparam int StallLimit = 20000;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [23:0] cfg_wdata_i;

  sbc_if #(.T(req_t)) req_ch ();
  sbc_if #(.T(res_t)) res_ch ();

  size_budget_oldest_evict_cache dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .cfg_we_i(cfg_we_i), .cfg_wdata_i(cfg_wdata_i),
    .req(req_ch), .res(res_ch)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Cache mirror
  logic [23:0] budget;
  logic        m_valid [Slots];
  logic [31:0] m_key   [Slots];
  logic [31:0] m_data  [Slots];
  logic [23:0] m_size  [Slots];
  logic [31:0] m_age   [Slots];
  logic [31:0] m_order [Slots];
  logic [31:0] stamp_ctr;
  logic [23:0] used_total;

  // Mirror snapshot around the typed-in checks
  logic        sv_valid [Slots];
  logic [31:0] sv_key   [Slots];
  logic [31:0] sv_data  [Slots];
  logic [23:0] sv_size  [Slots];
  logic [31:0] sv_age   [Slots];
  logic [31:0] sv_order [Slots];
  logic [31:0] sv_stamp;
  logic [23:0] sv_used;

  res_t expected_q[$];
  int errors = 0;
  int results_seen = 0;
  int items_sent = 0;
  int idle_cycles = 0;
  bit long_hold = 1'b0;

  function automatic logic [5:0] live_slots();
    int n;
    n = 0;
    for (int i = 0; i < Slots; i++) if (m_valid[i]) n++;
    return n[5:0];
  endfunction

  function automatic void push_result(status_e st, logic [31:0] key, logic [31:0] data);
    res_t r;
    r.status = st;
    r.entry_id_res = key;
    r.data_handle_res = data;
    r.used_size = used_total;
    r.entry_count = live_slots();
    r.last = 1'b0;
    expected_q.push_back(r);
  endfunction

  function automatic void shrink_total(logic [23:0] sz);
    used_total = (sz > used_total) ? 24'd0 : used_total - sz;
  endfunction

  // Predict the results of one accepted transaction
  function automatic void predict_cache(req_t rq);
    int n0, slot, old, hit;
    bit found;
    n0 = expected_q.size();
    case (kind_e'(rq.kind))
      KindStore: begin
        if (rq.entry_size > budget) begin
          push_result(StTooBig, rq.entry_id, '0);
        end else begin
          while ({1'b0, used_total} + {1'b0, rq.entry_size} > {1'b0, budget}) begin
            old = -1;
            for (int i = 0; i < Slots; i++)
              if (m_valid[i] && (old < 0 || m_age[i] < m_age[old])) old = i;
            if (old < 0) break;
            m_valid[old] = 1'b0;
            shrink_total(m_size[old]);
            push_result(StEvicted, m_key[old], m_data[old]);
          end
          slot = -1;
          for (int i = 0; i < Slots; i++)
            if (!m_valid[i] && slot < 0) slot = i;
          if (slot < 0) begin
            push_result(StNoRoom, rq.entry_id, '0);
          end else begin
            m_valid[slot] = 1'b1;
            m_key[slot] = rq.entry_id;
            m_data[slot] = rq.data_handle;
            m_size[slot] = rq.entry_size;
            m_age[slot] = stamp_ctr;
            m_order[slot] = stamp_ctr;
            stamp_ctr++;
            used_total = used_total + rq.entry_size;
            push_result(StStored, rq.entry_id, '0);
          end
        end
      end
      KindFetch: begin
        hit = -1;
        for (int i = 0; i < Slots; i++)
          if (m_valid[i] && m_key[i] == rq.entry_id && (hit < 0 || m_order[i] > m_order[hit]))
            hit = i;
        if (hit < 0) begin
          push_result(StMiss, rq.entry_id, '0);
        end else begin
          if (rq.touch) begin
            m_age[hit] = stamp_ctr;
            stamp_ctr++;
          end
          push_result(StHit, rq.entry_id, m_data[hit]);
        end
      end
      KindFree: begin
        found = 1'b0;
        for (int i = 0; i < Slots; i++) begin
          if (m_valid[i] && m_key[i] == rq.entry_id) begin
            found = 1'b1;
            m_valid[i] = 1'b0;
            shrink_total(m_size[i]);
            if (rq.notify) push_result(StFreed, rq.entry_id, m_data[i]);
          end
        end
        if (!found) push_result(StNotFnd, rq.entry_id, '0);
      end
      default: begin
        for (int i = 0; i < Slots; i++) begin
          if (m_valid[i]) begin
            m_valid[i] = 1'b0;
            shrink_total(m_size[i]);
            push_result(StResetN, m_key[i], m_data[i]);
          end
        end
        used_total = '0;
      end
    endcase
    if (expected_q.size() > n0) expected_q[expected_q.size() - 1].last = 1'b1;
  endfunction

  // Result receiver: a drawn wait before each transaction, one long hold-off
  initial begin
    int gap;
    res_ch.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      gap = $urandom_range(0, 19);
      if (long_hold) begin
        res_ch.ready <= 1'b0;
        repeat (400) @(negedge clk_i);
        long_hold = 1'b0;
      end
      if (gap > 0) begin
        res_ch.ready <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      res_ch.ready <= 1'b1;
      @(posedge clk_i);
      while (!res_ch.valid) @(posedge clk_i);
      @(negedge clk_i);
    end
  end

  // Sample accepted transactions on both channels
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (req_ch.valid && req_ch.ready) predict_cache(req_ch.data);
      if (res_ch.valid && res_ch.ready) begin
        results_seen++;
        if (expected_q.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected result: %p", res_ch.data);
        end else begin
          if (res_ch.data !== expected_q[0]) begin
            errors++;
            if (errors <= 10)
              $display("mismatch: expected %p, got %p", expected_q[0], res_ch.data);
          end
          void'(expected_q.pop_front());
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    if ((req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > StallLimit) begin
      $display("timeout");
      $display("testbench NOT OK");
      $finish;
    end
  end

  function automatic req_t make_req(kind_e k, logic [31:0] id, logic [31:0] dh,
                                    logic [23:0] sz, logic t, logic nt);
    req_t r;
    r.kind = k;
    r.entry_id = id;
    r.data_handle = dh;
    r.entry_size = sz;
    r.touch = t;
    r.notify = nt;
    return r;
  endfunction

  task automatic send_item(req_t rq);
    int gap;
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    req_ch.data  <= rq;
    req_ch.valid <= 1'b1;
    @(posedge clk_i);
    while (!req_ch.ready) @(posedge clk_i);
    items_sent++;
    @(negedge clk_i);
  endtask

  task automatic drain_cache();
    req_ch.valid <= 1'b0;
    while (expected_q.size() != 0) @(negedge clk_i);
    repeat (40) @(negedge clk_i);
  endtask

  task automatic write_budget(logic [23:0] v);
    drain_cache();
    cfg_wdata_i <= v;
    cfg_we_i <= 1'b1;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    budget = v;
  endtask

  // Random key from a small pool so hits and duplicates happen often
  function automatic logic [31:0] pick_key();
    return ($urandom_range(0, 9) == 0) ? $urandom() : 32'($urandom_range(0, 11));
  endfunction

  task automatic random_burst(int count, int max_sz);
    req_t rq;
    int k;
    for (int n = 0; n < count; n++) begin
      k = $urandom_range(0, 99);
      rq = make_req(k < 50 ? KindStore : k < 80 ? KindFetch : k < 97 ? KindFree : KindReset,
                    pick_key(), $urandom(), 24'($urandom_range(0, max_sz)),
                    1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      if ($urandom_range(0, 30) == 0) rq.entry_size = 24'($urandom());
      send_item(rq);
    end
  endtask

  dir_row_t dir_rows[$];

  initial begin
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_wdata_i = '0;
    req_ch.valid = 1'b0;
    req_ch.data = '0;
    budget = BudgetReset;
    stamp_ctr = '0;
    used_total = '0;
    for (int i = 0; i < Slots; i++) m_valid[i] = 1'b0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed table: empty cache responses, extremes, budget eviction
    dir_rows = '{
      '{make_req(KindFetch, 32'd5, 32'd0, 24'd0, 1'b1, 1'b0), 1'b1, StMiss},
      '{make_req(KindFree, 32'hFFFF_FFFF, 32'd0, 24'd0, 1'b0, 1'b1), 1'b1, StNotFnd},
      '{make_req(KindFree, 32'd0, 32'd0, 24'd0, 1'b0, 1'b0), 1'b1, StNotFnd},
      '{make_req(KindReset, 32'd0, 32'd0, 24'd0, 1'b0, 1'b0), 1'b0, StStored},
      '{make_req(KindStore, 32'd1, 32'hFFFF_FFFF, 24'hFF_FFFF, 1'b0, 1'b0), 1'b1, StTooBig},
      '{make_req(KindStore, 32'd1, 32'hFFFF_FFFF, 24'd0, 1'b1, 1'b1), 1'b1, StStored},
      '{make_req(KindStore, 32'hFFFF_FFFF, 32'hA5A5_5A5A, 24'd65536, 1'b0, 1'b0), 1'b0,
        StStored},
      '{make_req(KindStore, 32'd2, 32'd22, 24'd30000, 1'b0, 1'b0), 1'b0, StStored},
      '{make_req(KindStore, 32'd2, 32'd23, 24'd30000, 1'b0, 1'b0), 1'b0, StStored},
      '{make_req(KindFetch, 32'd2, 32'd0, 24'd0, 1'b1, 1'b0), 1'b1, StHit},
      '{make_req(KindStore, 32'd3, 32'd33, 24'd20000, 1'b0, 1'b0), 1'b0, StStored},
      '{make_req(KindFetch, 32'd2, 32'd0, 24'd0, 1'b0, 1'b0), 1'b0, StStored},
      '{make_req(KindFree, 32'd2, 32'd0, 24'd0, 1'b0, 1'b1), 1'b0, StStored},
      '{make_req(KindFree, 32'd3, 32'd0, 24'd0, 1'b0, 1'b0), 1'b0, StStored},
      '{make_req(KindFree, 32'd1, 32'd0, 24'd0, 1'b0, 1'b1), 1'b0, StStored},
      '{make_req(KindReset, 32'd0, 32'd0, 24'd0, 1'b0, 1'b0), 1'b0, StStored}
    };
    foreach (dir_rows[i]) begin
      if (dir_rows[i].chk_first) begin
        drain_cache();
        // check the typed-in status on a copy of the mirror, then put it back
        sv_valid = m_valid; sv_key = m_key; sv_data = m_data;
        sv_size = m_size; sv_age = m_age; sv_order = m_order;
        sv_stamp = stamp_ctr; sv_used = used_total;
        predict_cache(dir_rows[i].req);
        if (expected_q[0].status !== dir_rows[i].st_first) begin
          errors++;
          $display("row %0d: predicted status %0d, table says %0d",
                   i, expected_q[0].status, dir_rows[i].st_first);
        end
        expected_q.delete();
        m_valid = sv_valid; m_key = sv_key; m_data = sv_data;
        m_size = sv_size; m_age = sv_age; m_order = sv_order;
        stamp_ctr = sv_stamp; used_total = sv_used;
      end
      send_item(dir_rows[i].req);
    end

    // Table full: more zero-size stores than slots, then a reset that empties the table
    for (int i = 0; i < 34; i++)
      send_item(make_req(KindStore, 32'(i), $urandom(), 24'd0, 1'b0, 1'b0));
    send_item(make_req(KindReset, 32'd0, 32'd0, 24'd0, 1'b0, 1'b0));

    // Random phases over several budgets, with a long output hold-off in one
    random_burst(70, 20000);
    write_budget(24'd0);
    random_burst(20, 3);
    write_budget(24'hFF_FFFF);
    long_hold = 1'b1;
    random_burst(60, 24'hFF_FFFF);
    write_budget(24'd50000);
    random_burst(70, 9000);
    write_budget(24'd1000);
    random_burst(40, 800);

    drain_cache();
    $display("sent %0d requests, checked %0d results over five budget settings",
             items_sent, results_seen);
    if (errors == 0 && expected_q.size() == 0) begin
      $display("testbench OK");
    end else begin
      $display("%0d mismatches, %0d results outstanding", errors, expected_q.size());
      $display("testbench NOT OK");
    end
    $finish;
  end
endmodule
